// ===== rtl/core/assert_macros.svh =====
// assertion macros used by vector_set_length
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VSL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define VSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/vsl_pkg.sv =====
// constants for the vector set-length pipeline
// no dependencies
`timescale 1ns / 1ps

package vsl_pkg;

    // extra fraction bits carried by the computed length
    localparam int GUARD_BITS = 16;

endpackage

// ===== rtl/core/vsl_in_if.sv =====
// input channel: valid/ready handshake carrying one vector and a target length
// no dependencies
`timescale 1ns / 1ps

interface vsl_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic        [COORD_WIDTH-2:0] target_length;

    modport source (output valid, in_x, in_y, in_z, target_length, input ready);
    modport sink   (input valid, in_x, in_y, in_z, target_length, output ready);
endinterface

// ===== rtl/core/vsl_out_if.sv =====
// output channel: valid/ready handshake carrying one scaled vector and flags
// no dependencies
`timescale 1ns / 1ps

interface vsl_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          zero_length;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, zero_length, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, zero_length, saturated, output ready);
endinterface

// ===== rtl/core/vector_set_length.sv =====
// throughput: one request per cycle; the whole pipeline holds while a result waits
// the pipeline depth comes mostly from the square-root stages (two radicand bits each) and the dividers
// reset: rst_n clears all valid bits, the block takes requests right after reset
// depends on vsl_pkg, vsl_in_if, vsl_out_if, vsl_front, vsl_sqrt, vsl_div, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_set_length
    import vsl_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    vsl_in_if.sink    in_ch,
    vsl_out_if.source out_ch
);

    localparam int W      = COORD_WIDTH;
    localparam int NW     = 2 * W - 1 + GUARD_BITS;
    localparam int RB     = W + GUARD_BITS;
    localparam int SIDE_W = 4 + 3 * NW;

    logic              en;
    logic              f_valid, f_zero;
    logic [2*W-1:0]    f_s;
    logic [2:0]        f_neg;
    logic [NW-1:0]     f_num [3];
    logic              r_valid;
    logic [RB-1:0]     r_root;
    logic [SIDE_W-1:0] r_side;
    logic [NW-1:0]     r_num [3];
    logic [2:0]        r_neg;
    logic              r_zero;
    logic [2:0]        d_valid;
    logic [W-1:0]      d_q [3];
    logic [2:0]        d_ovf;
    logic [1:0]        d_side0;
    logic              d_side1, d_side2;
    logic [2:0]        c_neg;
    logic              c_zero;

    logic              valid_reg;
    logic [W-1:0]      res_reg [3];
    logic [W-1:0]      res_next [3];
    logic              zero_reg;
    logic              sat_reg, sat_next;

    assign en          = !valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    vsl_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .x         (in_ch.in_x),
        .y         (in_ch.in_y),
        .z         (in_ch.in_z),
        .tgt       (in_ch.target_length),
        .out_valid (f_valid),
        .s         (f_s),
        .zero      (f_zero),
        .neg       (f_neg),
        .num       (f_num)
    );

    vsl_sqrt #(.W(W), .SIDE_W(SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .s         (f_s),
        .side_in   ({f_neg, f_zero, f_num[0], f_num[1], f_num[2]}),
        .out_valid (r_valid),
        .root      (r_root),
        .side_out  (r_side)
    );

    assign {r_neg, r_zero, r_num[0], r_num[1], r_num[2]} = r_side;

    vsl_div #(.W(W), .SIDE_W(2)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .num       (r_num[0]),
        .d         (r_root),
        .side_in   ({r_neg[0], r_zero}),
        .out_valid (d_valid[0]),
        .q         (d_q[0]),
        .ovf       (d_ovf[0]),
        .side_out  (d_side0)
    );

    vsl_div #(.W(W), .SIDE_W(1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .num       (r_num[1]),
        .d         (r_root),
        .side_in   (r_neg[1]),
        .out_valid (d_valid[1]),
        .q         (d_q[1]),
        .ovf       (d_ovf[1]),
        .side_out  (d_side1)
    );

    vsl_div #(.W(W), .SIDE_W(1)) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .num       (r_num[2]),
        .d         (r_root),
        .side_in   (r_neg[2]),
        .out_valid (d_valid[2]),
        .q         (d_q[2]),
        .ovf       (d_ovf[2]),
        .side_out  (d_side2)
    );

    assign c_neg  = {d_side2, d_side1, d_side0[1]};
    assign c_zero = d_side0[0];

    // clip to the signed range, then restore the sign; a zero-length vector gives all zeros
    always_comb
    begin
        logic [W-1:0] lim;
        logic [W-1:0] m;
        logic         clip;
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lim  = c_neg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            clip = d_ovf[i] || (d_q[i] > lim);
            m    = clip ? lim : d_q[i];
            if (c_zero)
            begin
                res_next[i] = '0;
            end
            else
            begin
                res_next[i] = c_neg[i] ? W'(-m) : m;
                sat_next    = sat_next | clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= &d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg  <= res_next;
            zero_reg <= c_zero;
            sat_reg  <= sat_next;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_x       = res_reg[0];
    assign out_ch.out_y       = res_reg[1];
    assign out_ch.out_z       = res_reg[2];
    assign out_ch.zero_length = zero_reg;
    assign out_ch.saturated   = sat_reg;

    `VSL_ASSERT_IMPL(a_zero_clean, out_ch.valid && out_ch.zero_length, out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0 && !out_ch.saturated)
    `VSL_ASSERT_IMPL(a_stall_blocks, out_ch.valid && !out_ch.ready, !in_ch.ready)
    `VSL_ASSERT_IMPL(a_sat_at_limit, out_ch.valid && out_ch.saturated, out_ch.out_x == {1'b1, {(W-1){1'b0}}} || out_ch.out_x == {1'b0, {(W-1){1'b1}}} || out_ch.out_y == {1'b1, {(W-1){1'b0}}} || out_ch.out_y == {1'b0, {(W-1){1'b1}}} || out_ch.out_z == {1'b1, {(W-1){1'b0}}} || out_ch.out_z == {1'b0, {(W-1){1'b1}}})
    `VSL_ASSERT_IMPL(a_lanes_aligned, 1'b1, d_valid == 3'b000 || d_valid == 3'b111)

endmodule

// ===== rtl/core/vsl_front.sv =====
// front end: magnitudes, squares and scaled numerators, sum of squares
// depends on vsl_pkg
`timescale 1ns / 1ps

module vsl_front
    import vsl_pkg::*;
#(
    parameter int W  = 32,
    parameter int NW = 2 * W - 1 + GUARD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  x,
    input  logic signed [W-1:0]  y,
    input  logic signed [W-1:0]  z,
    input  logic        [W-2:0]  tgt,
    output logic                 out_valid,
    output logic [2*W-1:0]       s,
    output logic                 zero,
    output logic [2:0]           neg,
    output logic [NW-1:0]        num [3]
);

    logic [2:0]       v_reg;
    logic [W-1:0]     mag_reg [3];
    logic [W-1:0]     mag_next [3];
    logic [2:0]       neg0_reg, neg1_reg, neg2_reg;
    logic [2:0]       neg0_next;
    logic [W-2:0]     tgt_reg;
    logic [2*W-1:0]   sq_reg [3];
    logic [2*W-2:0]   prod_reg [3];
    logic [2*W-1:0]   s_reg;
    logic             zero_reg;
    logic [NW-1:0]    num_reg [3];
    logic [2*W-1:0]   s_next;

    always_comb
    begin
        neg0_next = {z[W-1], y[W-1], x[W-1]};
        // two's complement negate; the most negative value maps to 2^(W-1)
        mag_next[0] = x[W-1] ? W'(-x) : W'(x);
        mag_next[1] = y[W-1] ? W'(-y) : W'(y);
        mag_next[2] = z[W-1] ? W'(-z) : W'(z);
        s_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= mag_next[i];
                sq_reg[i]   <= {{W{1'b0}}, mag_reg[i]} * {{W{1'b0}}, mag_reg[i]};
                prod_reg[i] <= {{(W-1){1'b0}}, mag_reg[i]} * {{W{1'b0}}, tgt_reg};
                num_reg[i]  <= {prod_reg[i], {GUARD_BITS{1'b0}}};
            end
            neg0_reg <= neg0_next;
            neg1_reg <= neg0_reg;
            neg2_reg <= neg1_reg;
            tgt_reg  <= tgt;
            s_reg    <= s_next;
            zero_reg <= (s_next == '0);
        end
    end

    assign out_valid = v_reg[2];
    assign s         = s_reg;
    assign zero      = zero_reg;
    assign neg       = neg2_reg;
    assign num       = num_reg;

endmodule

// ===== rtl/core/vsl_sqrt.sv =====
// pipelined integer square root, two radicand bits per stage
// depends on vsl_pkg
`timescale 1ns / 1ps

module vsl_sqrt
    import vsl_pkg::*;
#(
    parameter int W      = 32,
    parameter int SIDE_W = 8,
    parameter int RB     = W + GUARD_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*W-1:0]    s,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [RB-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);

    logic              v_w    [RB+1];
    logic [RB:0]       rem_w  [RB+1];
    logic [RB-1:0]     root_w [RB+1];
    logic [2*RB-1:0]   rad_w  [RB+1];
    logic [SIDE_W-1:0] side_w [RB+1];

    assign v_w[0]    = in_valid;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rad_w[0]  = {s, {(2*GUARD_BITS){1'b0}}};
    assign side_w[0] = side_in;

    for (genvar k = 0; k < RB; k++)
    begin : g_stage
        logic              v_reg;
        logic [RB:0]       rem_reg, rem_next;
        logic [RB-1:0]     root_reg, root_next;
        logic [2*RB-1:0]   rad_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [RB+2:0]     rt, tt;

        always_comb
        begin
            rt = {rem_w[k], rad_w[k][2*RB-1 -: 2]};
            tt = {1'b0, root_w[k], 2'b01};
            if (rt >= tt)
            begin
                rem_next  = (RB+1)'(rt - tt);
                root_next = {root_w[k][RB-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rt[RB:0];
                root_next = {root_w[k][RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= {rad_w[k][2*RB-3:0], 2'b00};
                side_reg <= side_w[k];
            end
        end

        assign v_w[k+1]    = v_reg;
        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign rad_w[k+1]  = rad_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid = v_w[RB];
    assign root      = root_w[RB];
    assign side_out  = side_w[RB];

endmodule

// ===== rtl/core/vsl_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow check
// depends on vsl_pkg
`timescale 1ns / 1ps

module vsl_div
    import vsl_pkg::*;
#(
    parameter int W      = 32,
    parameter int DW     = W + GUARD_BITS,
    parameter int NW     = 2 * W - 1 + GUARD_BITS,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     num,
    input  logic [DW-1:0]     d,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [W-1:0]      q,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out
);

    logic              v_w    [W+1];
    logic [DW-1:0]     rem_w  [W+1];
    logic [DW-1:0]     d_w    [W+1];
    logic [W-1:0]      low_w  [W+1];
    logic [W-1:0]      q_w    [W+1];
    logic              ovf_w  [W+1];
    logic [SIDE_W-1:0] side_w [W+1];

    logic              v0_reg;
    logic [DW-1:0]     rem0_reg, d0_reg;
    logic [W-1:0]      low0_reg;
    logic              ovf0_reg;
    logic [SIDE_W-1:0] side0_reg;
    logic [DW-1:0]     hi_part;

    // quotient fits in W bits exactly when the upper numerator part is below d
    assign hi_part = DW'(num >> W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg  <= hi_part;
            d0_reg    <= d;
            low0_reg  <= num[W-1:0];
            ovf0_reg  <= (hi_part >= d);
            side0_reg <= side_in;
        end
    end

    assign v_w[0]    = v0_reg;
    assign rem_w[0]  = rem0_reg;
    assign d_w[0]    = d0_reg;
    assign low_w[0]  = low0_reg;
    assign q_w[0]    = '0;
    assign ovf_w[0]  = ovf0_reg;
    assign side_w[0] = side0_reg;

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        logic              v_reg;
        logic [DW-1:0]     rem_reg, rem_next;
        logic [DW-1:0]     d_reg;
        logic [W-1:0]      low_reg;
        logic [W-1:0]      q_reg, q_next;
        logic              ovf_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [DW:0]       rt;

        always_comb
        begin
            rt = {rem_w[k], low_w[k][W-1]};
            if (rt >= {1'b0, d_w[k]})
            begin
                rem_next = DW'(rt - {1'b0, d_w[k]});
                q_next   = {q_w[k][W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rt[DW-1:0];
                q_next   = {q_w[k][W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                d_reg    <= d_w[k];
                low_reg  <= {low_w[k][W-2:0], 1'b0};
                q_reg    <= q_next;
                ovf_reg  <= ovf_w[k];
                side_reg <= side_w[k];
            end
        end

        assign v_w[k+1]    = v_reg;
        assign rem_w[k+1]  = rem_reg;
        assign d_w[k+1]    = d_reg;
        assign low_w[k+1]  = low_reg;
        assign q_w[k+1]    = q_reg;
        assign ovf_w[k+1]  = ovf_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid = v_w[W];
    assign q         = q_w[W];
    assign ovf       = ovf_w[W];
    assign side_out  = side_w[W];

endmodule

// ===== sim/vsl_checker.sv =====
// checker for vector_set_length: watches both channels, predicts each result
// and compares it field by field; depends on vsl_pkg, vsl_in_if, vsl_out_if
`timescale 1ns / 1ps

module vsl_checker
    import vsl_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    vsl_in_if.sink    in_ch,
    vsl_out_if.sink   out_ch,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   zero_len;
        logic                   sat;
    } scaled_vec_t;

    scaled_vec_t expected_vecs[$];

    // integer square root, floor, of a 128-bit value
    function automatic logic [127:0] isqrt128(input logic [127:0] n);
        logic [127:0] res;
        logic [127:0] bitv;
        logic [127:0] t;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0)
        begin
            t = res + bitv;
            if (n >= t)
            begin
                n   = n - t;
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic scaled_vec_t scale_vector(input logic [COORD_WIDTH-1:0] cx,
                                                 input logic [COORD_WIDTH-1:0] cy,
                                                 input logic [COORD_WIDTH-1:0] cz,
                                                 input logic [COORD_WIDTH-2:0] tgt);
        logic [COORD_WIDTH-1:0] comp[3];
        logic [COORD_WIDTH-1:0] mag[3];
        logic                   neg[3];
        logic [127:0]           sum_sq;
        logic [127:0]           len;
        logic [127:0]           quot;
        logic [127:0]           lim;
        logic [COORD_WIDTH-1:0] m;
        logic [COORD_WIDTH-1:0] outc[3];
        scaled_vec_t            r;
        comp[0] = cx;
        comp[1] = cy;
        comp[2] = cz;
        sum_sq  = '0;
        r       = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i]  = comp[i][COORD_WIDTH-1];
            // most negative value negates to itself, which is its magnitude
            mag[i]  = neg[i] ? -comp[i] : comp[i];
            sum_sq += 128'(mag[i]) * 128'(mag[i]);
        end
        if (sum_sq == 0)
        begin
            r.zero_len = 1'b1;
            return r;
        end
        len = isqrt128(sum_sq << (2 * GUARD_BITS));
        for (int i = 0; i < 3; i++)
        begin
            quot = ((128'(mag[i]) * 128'(tgt)) << GUARD_BITS) / len;
            lim  = neg[i] ? (128'd1 << (COORD_WIDTH-1)) : ((128'd1 << (COORD_WIDTH-1)) - 1);
            if (quot > lim)
            begin
                m     = lim[COORD_WIDTH-1:0];
                r.sat = 1'b1;
            end
            else
                m = quot[COORD_WIDTH-1:0];
            outc[i] = neg[i] ? -m : m;
        end
        r.x = outc[0];
        r.y = outc[1];
        r.z = outc[2];
        return r;
    endfunction

    assign pending = expected_vecs.size();

    always @(posedge clk or negedge rst_n)
    begin
        scaled_vec_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_vecs.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_vecs.push_back(scale_vector(in_ch.in_x, in_ch.in_y, in_ch.in_z,
                                                     in_ch.target_length));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_vecs.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_vecs.pop_front();
                    if (out_ch.out_x !== e.x || out_ch.out_y !== e.y || out_ch.out_z !== e.z
                        || out_ch.zero_length !== e.zero_len || out_ch.saturated !== e.sat)
                        fail_count <= fail_count + 1;
                    if (out_ch.out_x !== e.x)
                        $error("out_x expected %0d got %0d", $signed(e.x), out_ch.out_x);
                    if (out_ch.out_y !== e.y)
                        $error("out_y expected %0d got %0d", $signed(e.y), out_ch.out_y);
                    if (out_ch.out_z !== e.z)
                        $error("out_z expected %0d got %0d", $signed(e.z), out_ch.out_z);
                    if (out_ch.zero_length !== e.zero_len)
                        $error("zero_length expected %0b got %0b", e.zero_len,
                               out_ch.zero_length);
                    if (out_ch.saturated !== e.sat)
                        $error("saturated expected %0b got %0b", e.sat, out_ch.saturated);
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
// testbench top for vector_set_length: drives requests with random idling,
// stalls the result side and gives the verdict; depends on vector_set_length, vsl_checker, vsl_in_if, vsl_out_if
`timescale 1ns / 1ps

module tb;

    localparam int CW         = 32;
    localparam int LATENCY    = 2 * CW + 21;
    localparam int STALL_MAX  = 20000;
    localparam int ONE        = 65536;

    localparam logic [CW-2:0] ONE_T  = (CW-1)'(ONE);
    localparam logic [CW-2:0] TGT_0  = '0;
    localparam logic [CW-2:0] TGT_1  = (CW-1)'(1);

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   snk_hold;
    int   idle_cycles = 0;

    vsl_in_if  #(.COORD_WIDTH(CW)) in_ch ();
    vsl_out_if #(.COORD_WIDTH(CW)) out_ch ();

    vector_set_length #(.COORD_WIDTH(CW)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    vsl_checker #(.COORD_WIDTH(CW)) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.sink),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: random stalls, or a long hold while snk_hold is set
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            out_ch.ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles with no handshake at all, paused while snk_hold is set
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || snk_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return CW'($urandom_range(3)) - 2;
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return {1'b0, {(CW-1){1'b1}}};
            3: return CW'($signed($urandom_range(65535)) - 32768) <<< $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CW-2:0] rand_target();
        case ($urandom_range(4))
            0: return ONE_T;
            1: return (CW-1)'($urandom_range(3));
            2: return {(CW-1){1'b1}};
            default: return (CW-1)'($urandom);
        endcase
    endfunction

    // offer one request and hold it until it is taken
    task automatic send_vector(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                               input logic [CW-1:0] vz, input logic [CW-2:0] tl);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_x          <= vx;
        in_ch.in_y          <= vy;
        in_ch.in_z          <= vz;
        in_ch.target_length <= tl;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MAXN = {1'b1, {(CW-1){1'b0}}};

    initial
    begin
        in_ch.valid         = 1'b0;
        in_ch.in_x          = '0;
        in_ch.in_y          = '0;
        in_ch.in_z          = '0;
        in_ch.target_length = '0;
        src_idle_pct        = 0;
        snk_idle_pct        = 0;
        snk_hold            = 1'b0;
        @(posedge clk iff rst_n);

        // directed: zero vector, zero target, unit axes, extremes, saturation
        send_vector(0, 0, 0, ONE_T);
        send_vector(0, 0, 0, {(CW-1){1'b1}});
        send_vector(ONE, 0, 0, TGT_0);
        send_vector(ONE, 0, 0, ONE_T);
        send_vector(0, -ONE, 0, ONE_T);
        send_vector(0, 0, ONE, ONE_T);
        send_vector(3 * ONE, 4 * ONE, 0, ONE_T);
        send_vector(MAXP, MAXP, MAXP, ONE_T);
        send_vector(MAXN, MAXN, MAXN, ONE_T);
        send_vector(MAXN, 0, 0, {(CW-1){1'b1}});
        send_vector(MAXP, 0, 0, {(CW-1){1'b1}});
        send_vector(1, 0, 0, {(CW-1){1'b1}});
        send_vector(-1, 0, 0, {(CW-1){1'b1}});
        send_vector(1, 1, 1, {(CW-1){1'b1}});
        send_vector(-1, -1, -1, TGT_1);
        send_vector(MAXN, MAXP, 1, ONE_T);
        send_vector(1, 0, 0, TGT_1);
        send_vector(-32'sd1, 32'sd1, 32'sd0, 31'd2);
        drain();

        // long receiver hold while requests keep coming, then a full pause
        snk_hold = 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(posedge clk);
                snk_hold = 1'b0;
            end
            repeat (200)
                send_vector(rand_coord(), rand_coord(), rand_coord(), rand_target());
        join
        drain();

        src_idle_pct = 30;
        snk_idle_pct = 74;
        repeat (450)
            send_vector(rand_coord(), rand_coord(), rand_coord(), rand_target());
        src_idle_pct = 74;
        snk_idle_pct = 30;
        repeat (450)
            send_vector(rand_coord(), rand_coord(), rand_coord(), rand_target());
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (450)
            send_vector(rand_coord(), rand_coord(), rand_coord(), rand_target());
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
